// ===== design/bed_pkg.sv =====
// Shared types and constants for the backslash escape decoder.
// Used by bed_front, bed_queue, bed_back and backslash_escape_decoder_unit.
// No dependencies.
package bed_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_mark;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_status;
		logic       all_valid;
		logic       run_last;
	} out_beat_t;

	// one decoded item: up to two result beats
	typedef struct packed {
		out_beat_t res0;
		out_beat_t res1;
		logic      dual;
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_ESCAPE = 2'd1,
		MODE_OCT1   = 2'd2,
		MODE_OCT2   = 2'd3
	} mode_t;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [4:0] OCT_HI    = 5'b00110; // '0'..'7' share these upper bits

	localparam logic [7:0] CODE_LF  = 8'h0A;
	localparam logic [7:0] CODE_TAB = 8'h09;
	localparam logic [7:0] CODE_FF  = 8'h0C;
	localparam logic [7:0] CODE_BS  = 8'h08;
	localparam logic [7:0] CODE_CR  = 8'h0D;
	localparam logic [7:0] CODE_DEL = 8'h7F;

endpackage

// ===== design/bed_front.sv =====
// Front end: accepts input beats, runs the escape state machine and
// produces one command per item that has results. Depends on bed_pkg.
module bed_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic             item_stall,
	input  bed_pkg::in_beat_t item,
	output logic             push,
	output bed_pkg::cmd_t    cmd
);

	bed_pkg::mode_t mode_q, mode_d;
	logic [7:0]     oct_q, oct_d;
	logic           flag_q, flag_d;
	logic           has_res;
	logic           accept;
	logic           is_oct;
	logic [7:0]     acc;
	logic [7:0]     b;

	assign accept = item_valid && !item_stall;
	assign b      = item.in_byte;
	assign is_oct = (b[7:3] == bed_pkg::OCT_HI);
	assign acc    = {oct_q[4:0], b[2:0]};
	assign push   = accept && has_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= bed_pkg::MODE_NORMAL;
			oct_q  <= 8'd0;
			flag_q <= 1'b1;
		end else if (accept) begin
			mode_q <= mode_d;
			oct_q  <= oct_d;
			flag_q <= flag_d;
		end
	end

	always_comb begin
		mode_d  = mode_q;
		oct_d   = oct_q;
		flag_d  = flag_q;
		has_res = 1'b0;
		cmd     = '0;
		if (item.end_mark) begin
			has_res = 1'b1;
			unique case (mode_q)
				bed_pkg::MODE_ESCAPE: begin
					cmd.res0.out_byte  = bed_pkg::CH_BSLASH;
					cmd.res1.is_status = 1'b1;
					cmd.res1.all_valid = 1'b0;
					cmd.dual           = 1'b1;
				end
				bed_pkg::MODE_OCT1, bed_pkg::MODE_OCT2: begin
					cmd.res0.out_byte  = oct_q;
					cmd.res1.is_status = 1'b1;
					cmd.res1.all_valid = flag_q;
					cmd.dual           = 1'b1;
				end
				bed_pkg::MODE_NORMAL: begin
					cmd.res0.is_status = 1'b1;
					cmd.res0.all_valid = flag_q;
				end
				default: ;
			endcase
			mode_d = bed_pkg::MODE_NORMAL;
			oct_d  = 8'd0;
			flag_d = 1'b1;
		end else begin
			unique case (mode_q)
				bed_pkg::MODE_NORMAL: begin
					if (b == bed_pkg::CH_BSLASH) begin
						mode_d = bed_pkg::MODE_ESCAPE;
					end else begin
						has_res           = 1'b1;
						cmd.res0.out_byte = b;
					end
				end
				bed_pkg::MODE_ESCAPE: begin
					mode_d  = bed_pkg::MODE_NORMAL;
					has_res = 1'b1;
					unique case (b)
						bed_pkg::CH_BSLASH: cmd.res0.out_byte = bed_pkg::CH_BSLASH;
						bed_pkg::CH_N:      cmd.res0.out_byte = bed_pkg::CODE_LF;
						bed_pkg::CH_T:      cmd.res0.out_byte = bed_pkg::CODE_TAB;
						bed_pkg::CH_F:      cmd.res0.out_byte = bed_pkg::CODE_FF;
						bed_pkg::CH_B:      cmd.res0.out_byte = bed_pkg::CODE_BS;
						bed_pkg::CH_R:      cmd.res0.out_byte = bed_pkg::CODE_CR;
						bed_pkg::CH_QMARK:  cmd.res0.out_byte = bed_pkg::CODE_DEL;
						default: begin
							if (is_oct) begin
								has_res = 1'b0;
								oct_d   = {5'd0, b[2:0]};
								mode_d  = bed_pkg::MODE_OCT1;
							end else begin
								flag_d            = 1'b0;
								cmd.res0.out_byte = bed_pkg::CH_BSLASH;
								cmd.res1.out_byte = b;
								cmd.dual          = 1'b1;
							end
						end
					endcase
				end
				bed_pkg::MODE_OCT1, bed_pkg::MODE_OCT2: begin
					if (is_oct) begin
						oct_d = acc;
						if (mode_q == bed_pkg::MODE_OCT1) begin
							mode_d = bed_pkg::MODE_OCT2;
						end else begin
							mode_d            = bed_pkg::MODE_NORMAL;
							has_res           = 1'b1;
							cmd.res0.out_byte = acc;
						end
					end else begin
						has_res           = 1'b1;
						cmd.res0.out_byte = oct_q;
						if (b == bed_pkg::CH_BSLASH) begin
							mode_d = bed_pkg::MODE_ESCAPE;
						end else begin
							mode_d            = bed_pkg::MODE_NORMAL;
							cmd.res1.out_byte = b;
							cmd.dual          = 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
		cmd.res0.run_last = !cmd.dual;
		cmd.res1.run_last = 1'b1;
	end

endmodule

// ===== design/bed_queue.sv =====
// Command queue between front and back end, QDEPTH entries.
// Depends on bed_pkg.
module bed_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bed_pkg::cmd_t push_cmd,
	input  logic          pop,
	output logic          full,
	output logic          head_valid,
	output bed_pkg::cmd_t head_cmd
);

	bed_pkg::cmd_t                 ent_q [bed_pkg::QDEPTH];
	logic [bed_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [bed_pkg::QCNT_W-1:0]    cnt_q;
	logic                          do_pop;

	assign full       = (cnt_q == bed_pkg::QCNT_W'(bed_pkg::QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_cmd   = ent_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/bed_back.sv =====
// Back end: expands each queued command into one or two result beats
// and holds them in the output register. Depends on bed_pkg.
module bed_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  bed_pkg::cmd_t      head_cmd,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_stall,
	output bed_pkg::out_beat_t result
);

	logic               valid_q;
	logic               phase_q;
	logic               load;
	bed_pkg::out_beat_t out_q;

	assign load         = !valid_q || !result_stall;
	assign pop          = load && head_valid && (phase_q || !head_cmd.dual);
	assign result_valid = valid_q;
	assign result       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (load) begin
			valid_q <= head_valid;
			if (head_valid) begin
				phase_q <= !phase_q && head_cmd.dual;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			out_q <= phase_q ? head_cmd.res1 : head_cmd.res0;
		end
	end

endmodule

// ===== design/backslash_escape_decoder_unit.sv =====
// Top level of the backslash escape decoder: front end, command queue, back end.
// Depends on bed_pkg, bed_front, bed_queue, bed_back.
//
//   channel  payload              handshake
//   item     bed_pkg::in_beat_t   item_valid / item_stall
//   result   bed_pkg::out_beat_t  result_valid / result_stall
//
// One input beat per cycle while the queue has room; item_stall is the
// queue-full flag. The back end sends one result beat per cycle while
// result_stall is low. A result passes through a queue entry and the output
// register. Reset is asynchronous and clears decode state and queue.
module backslash_escape_decoder_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  bed_pkg::in_beat_t  item,
	output logic               result_valid,
	input  logic               result_stall,
	output bed_pkg::out_beat_t result
);

	logic          push;
	bed_pkg::cmd_t push_cmd;
	logic          pop;
	logic          full;
	logic          head_valid;
	bed_pkg::cmd_t head_cmd;

	assign item_stall = full;

	bed_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.push       (push),
		.cmd        (push_cmd)
	);

	bed_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	bed_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_cmd     (head_cmd),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
